### rtl/core/assert_macros.svh
// Assertion macros shared by the packetizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/core/h264fu_pkg.sv
// Types and constants for the H.264 RTP FU-A packetizer.
package h264fu_pkg;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1400;
  localparam logic [15:0] MIN_PAYLOAD       = 16'd3;
  localparam logic [7:0]  NRI_MASK          = 8'hE0;
  localparam logic [7:0]  FU_A_TYPE         = 8'd28;
  localparam int          RES_MAX           = 3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_nal;
    logic [15:0] nal_length;
    logic        channel;
    logic [31:0] frame_timestamp;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_start;
    logic        packet_end;
    logic [15:0] payload_length;
    logic        frame_marker;
    logic        out_channel;
    logic [31:0] out_timestamp;
    logic        run_last;
  } out_item_t;

  typedef out_item_t [RES_MAX-1:0] res_vec_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_vec_t   res;
  } step_t;

endpackage

### rtl/core/h264fu_ctx.sv
// Packetizer context registers and per-byte result generation.
module h264fu_ctx
  import h264fu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    item,
  input  logic        consume,
  input  logic [15:0] max_payload,
  output step_t       step
);

  logic        fragment_mode, fragment_mode_next;
  logic [7:0]  fu_indicator_byte, fu_indicator_byte_next;
  logic [4:0]  nal_type_bits, nal_type_bits_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] chunk_left, chunk_left_next;
  logic        first_fragment_flag, first_fragment_flag_next;
  logic        final_fragment_flag, final_fragment_flag_next;

  logic [15:0] mp;
  logic [15:0] len_e;
  logic [15:0] chunk;
  logic        fin;
  logic [7:0]  hdr;
  out_item_t   base;

  always_comb begin
    mp    = (max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload;
    len_e = (item.nal_length == 16'd0) ? 16'd1 : item.nal_length;

    fragment_mode_next       = fragment_mode;
    fu_indicator_byte_next   = fu_indicator_byte;
    nal_type_bits_next       = nal_type_bits;
    bytes_remaining_next     = bytes_remaining;
    chunk_left_next          = chunk_left;
    first_fragment_flag_next = first_fragment_flag;
    final_fragment_flag_next = final_fragment_flag;

    if (({1'b0, bytes_remaining} + 17'd2) > {1'b0, mp}) begin
      chunk = mp - 16'd2;
      fin   = 1'b0;
    end else begin
      chunk = bytes_remaining;
      fin   = 1'b1;
    end
    hdr = {first_fragment_flag, fin, 1'b0, nal_type_bits};

    base                = '0;
    base.out_channel    = item.channel;
    base.out_timestamp  = item.frame_timestamp;
    step                = '0;

    if (item.first_of_nal) begin
      bytes_remaining_next = len_e - 16'd1;
      chunk_left_next      = 16'd0;
      if (len_e <= mp) begin
        fragment_mode_next       = 1'b0;
        final_fragment_flag_next = 1'b1;
        step.cnt                       = 2'd1;
        step.res[0]                    = base;
        step.res[0].out_byte           = item.data_byte;
        step.res[0].packet_start       = 1'b1;
        step.res[0].packet_end         = (len_e == 16'd1);
        step.res[0].payload_length     = len_e;
        step.res[0].frame_marker       = 1'b1;
        step.res[0].run_last           = 1'b1;
      end else begin
        fragment_mode_next       = 1'b1;
        fu_indicator_byte_next   = (item.data_byte & NRI_MASK) | FU_A_TYPE;
        nal_type_bits_next       = item.data_byte[4:0];
        first_fragment_flag_next = 1'b1;
        final_fragment_flag_next = 1'b0;
      end
    end else if (bytes_remaining != 16'd0) begin
      bytes_remaining_next = bytes_remaining - 16'd1;
      if (!fragment_mode) begin
        step.cnt                 = 2'd1;
        step.res[0]              = base;
        step.res[0].out_byte     = item.data_byte;
        step.res[0].packet_end   = (bytes_remaining == 16'd1);
        step.res[0].frame_marker = 1'b1;
        step.res[0].run_last     = 1'b1;
      end else if (chunk_left == 16'd0) begin
        first_fragment_flag_next   = 1'b0;
        final_fragment_flag_next   = fin;
        chunk_left_next            = chunk - 16'd1;
        step.cnt                   = 2'd3;
        step.res[0]                = base;
        step.res[0].out_byte       = fu_indicator_byte;
        step.res[0].packet_start   = 1'b1;
        step.res[0].payload_length = chunk + 16'd2;
        step.res[0].frame_marker   = fin;
        step.res[1]                = base;
        step.res[1].out_byte       = hdr;
        step.res[1].frame_marker   = fin;
        step.res[2]                = base;
        step.res[2].out_byte       = item.data_byte;
        step.res[2].packet_end     = (chunk == 16'd1);
        step.res[2].frame_marker   = fin;
        step.res[2].run_last       = 1'b1;
      end else begin
        chunk_left_next          = chunk_left - 16'd1;
        step.cnt                 = 2'd1;
        step.res[0]              = base;
        step.res[0].out_byte     = item.data_byte;
        step.res[0].packet_end   = (chunk_left == 16'd1);
        step.res[0].frame_marker = final_fragment_flag;
        step.res[0].run_last     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_mode       <= 1'b0;
      fu_indicator_byte   <= 8'd0;
      nal_type_bits       <= 5'd0;
      bytes_remaining     <= 16'd0;
      chunk_left          <= 16'd0;
      first_fragment_flag <= 1'b1;
      final_fragment_flag <= 1'b0;
    end else if (consume) begin
      fragment_mode       <= fragment_mode_next;
      fu_indicator_byte   <= fu_indicator_byte_next;
      nal_type_bits       <= nal_type_bits_next;
      bytes_remaining     <= bytes_remaining_next;
      chunk_left          <= chunk_left_next;
      first_fragment_flag <= first_fragment_flag_next;
      final_fragment_flag <= final_fragment_flag_next;
    end
  end

endmodule

### rtl/core/h264fu_oreg.sv
// Output result register with valid/stall handshake.
module h264fu_oreg
  import h264fu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t d,
  input  logic      stall,
  output logic      valid,
  output out_item_t q,
  output logic      free
);

  assign free = !valid || !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      q <= d;
    end
  end

endmodule

### rtl/core/h264_rtp_fu_a_packetizer_unit.sv
// Top level of the H.264 RTP FU-A packetizer.
//
//   channel   direction  handshake          payload
//   in        input      in_valid/in_stall  in_item_t  (one NAL byte)
//   out       output     out_valid/out_stall out_item_t (one payload byte)
//   cfg       input      cfg_valid/cfg_ready 16-bit max_payload
//
// A byte sits in the input register until all its results are loaded: one
// result, or three when it opens a fragment (indicator, FU header, data), or
// none at all. The single output register sets the pace: one result per cycle
// while out is not stalled. Synchronous reset clears the context and both
// valid flags and loads max_payload with 1400. A stall on out holds the output
// register and back-pressures in once the input register is occupied.
`include "assert_macros.svh"
module h264_rtp_fu_a_packetizer_unit
  import h264fu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] max_payload;
  logic        iv;
  in_item_t    item;
  logic [1:0]  idx;
  step_t       step;
  logic        out_free;
  logic        load;
  logic        is_last;
  logic        consume;
  out_item_t   sel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload <= cfg_data;
    end
  end

  h264fu_ctx u_ctx (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .consume     (consume),
    .max_payload (max_payload),
    .step        (step)
  );

  always_comb begin
    case (idx)
      2'd0:    sel = step.res[0];
      2'd1:    sel = step.res[1];
      2'd2:    sel = step.res[2];
      default: sel = step.res[0];
    endcase
  end

  assign is_last  = (idx == step.cnt - 2'd1);
  assign load     = iv && (step.cnt != 2'd0) && out_free;
  assign consume  = iv && ((step.cnt == 2'd0) || (out_free && is_last));
  assign in_stall = iv && !consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv  <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (in_valid && !in_stall) begin
        iv <= 1'b1;
      end else if (consume) begin
        iv <= 1'b0;
      end
      if (consume) begin
        idx <= 2'd0;
      end else if (load) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  h264fu_oreg u_oreg (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .d     (sel),
    .stall (out_stall),
    .valid (out_valid),
    .q     (out_data),
    .free  (out_free)
  );

  `ASSERT_IMPLIES(a_idx_range, clk, rst, iv && step.cnt != 2'd0, idx < step.cnt)
  `ASSERT_IMPLIES(a_idx_idle, clk, rst, !iv, idx == 2'd0)
  `ASSERT_IMPLIES(a_item_held, clk, rst, load && !is_last, ##1 iv)
  `ASSERT_IMPLIES(a_out_rise, clk, rst, $rose(out_valid), $past(load))

endmodule

### dv/h264_fu_a_checker.sv
`timescale 1ns / 1ps
// Checker for the FU-A packetizer: predicts RTP payload bytes and compares transfers.
module h264_fu_a_checker
  import h264fu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  logic [15:0] max_payload;
  logic        frag_mode;
  logic        first_frag;
  logic        final_frag;
  logic [7:0]  fu_indicator;
  logic [4:0]  nal_type;
  logic [15:0] bytes_left;
  logic [15:0] chunk_left;
  out_item_t   rtp_bytes_q[$];
  out_item_t   want;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    fail_count++;
    if (fail_count <= 50)
      $display("mismatch %s: got 0x%0h exp 0x%0h", what, got, exp_val);
  endtask

  function automatic out_item_t rtp_byte(input logic [7:0] b, input logic ps,
                                         input logic pe, input logic [15:0] len,
                                         input logic mark, input in_item_t it);
    out_item_t r;
    r.out_byte       = b;
    r.packet_start   = ps;
    r.packet_end     = pe;
    r.payload_length = len;
    r.frame_marker   = mark;
    r.out_channel    = it.channel;
    r.out_timestamp  = it.frame_timestamp;
    r.run_last       = 1'b0;
    return r;
  endfunction

  function automatic void packetize_byte(input in_item_t it);
    out_item_t   res [RES_MAX];
    int          n;
    int unsigned eff;
    int unsigned nlen;
    int unsigned chunk;
    logic [7:0]  fu_hdr;
    n = 0;
    eff = (max_payload < MIN_PAYLOAD) ? MIN_PAYLOAD : max_payload;
    if (it.first_of_nal) begin
      nlen = (it.nal_length == 16'd0) ? 1 : it.nal_length;
      bytes_left = 16'(nlen - 1);
      chunk_left = '0;
      if (nlen <= eff) begin
        frag_mode = 1'b0;
        final_frag = 1'b1;
        res[n] = rtp_byte(it.data_byte, 1'b1, nlen == 1, 16'(nlen), 1'b1, it);
        n = n + 1;
      end else begin
        frag_mode = 1'b1;
        fu_indicator = (it.data_byte & NRI_MASK) | FU_A_TYPE;
        nal_type = it.data_byte[4:0];
        first_frag = 1'b1;
        final_frag = 1'b0;
      end
    end else if (bytes_left != 16'd0) begin
      if (!frag_mode) begin
        res[n] = rtp_byte(it.data_byte, 1'b0, bytes_left == 16'd1, '0, 1'b1, it);
        n = n + 1;
        bytes_left--;
      end else begin
        if (chunk_left == 16'd0) begin
          if (bytes_left + 2 > eff) begin
            chunk = eff - 2;
            final_frag = 1'b0;
          end else begin
            chunk = bytes_left;
            final_frag = 1'b1;
          end
          // FU header: start, end, reserved, type
          fu_hdr = {first_frag, final_frag, 1'b0, nal_type};
          first_frag = 1'b0;
          chunk_left = 16'(chunk);
          res[n] = rtp_byte(fu_indicator, 1'b1, 1'b0, 16'(chunk + 2), final_frag, it);
          res[n + 1] = rtp_byte(fu_hdr, 1'b0, 1'b0, '0, final_frag, it);
          n = n + 2;
        end
        res[n] = rtp_byte(it.data_byte, 1'b0, chunk_left == 16'd1, '0, final_frag, it);
        n = n + 1;
        chunk_left--;
        bytes_left--;
      end
    end
    if (n > 0)
      res[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++)
      rtp_bytes_q.push_back(res[i]);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      max_payload = MAX_PAYLOAD_RESET;
      frag_mode = 1'b0;
      fu_indicator = '0;
      nal_type = '0;
      bytes_left = '0;
      chunk_left = '0;
      first_frag = 1'b1;
      final_frag = 1'b0;
      rtp_bytes_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (rtp_bytes_q.size() == 0) begin
          report_mismatch("unexpected transfer", out_data.out_byte, '0);
        end else begin
          want = rtp_bytes_q.pop_front();
          if (out_data.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_data.out_byte, want.out_byte);
          if (out_data.packet_start !== want.packet_start)
            report_mismatch("packet_start", out_data.packet_start, want.packet_start);
          if (out_data.packet_end !== want.packet_end)
            report_mismatch("packet_end", out_data.packet_end, want.packet_end);
          if (out_data.payload_length !== want.payload_length)
            report_mismatch("payload_length", out_data.payload_length,
                            want.payload_length);
          if (out_data.frame_marker !== want.frame_marker)
            report_mismatch("frame_marker", out_data.frame_marker, want.frame_marker);
          if (out_data.out_channel !== want.out_channel)
            report_mismatch("out_channel", out_data.out_channel, want.out_channel);
          if (out_data.out_timestamp !== want.out_timestamp)
            report_mismatch("out_timestamp", out_data.out_timestamp, want.out_timestamp);
          if (out_data.run_last !== want.run_last)
            report_mismatch("run_last", out_data.run_last, want.run_last);
        end
      end
      if (cfg_valid && cfg_ready)
        max_payload = cfg_data;
      if (in_valid && !in_stall)
        packetize_byte(in_data);
    end
    pending = rtp_bytes_q.size();
  end

endmodule

### dv/tb_h264_rtp_fu_a_packetizer_unit.sv
`timescale 1ns / 1ps
// Testbench top for the FU-A packetizer: clock, reset, stimulus, backpressure and verdict.
module tb_h264_rtp_fu_a_packetizer_unit;
  import h264fu_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  int          hold_token = 0;
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  h264_rtp_fu_a_packetizer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  h264_fu_a_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver backpressure
  initial begin : sink_ctl
    int n;
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_token != holds_done) begin
        holds_done = hold_token;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input in_item_t it);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic [15:0] len,
                           input logic ch, input logic [31:0] ts);
    in_item_t it;
    it.data_byte = b;
    it.first_of_nal = first;
    it.nal_length = len;
    it.channel = ch;
    it.frame_timestamp = ts;
    send_item(it);
  endtask

  task automatic send_nal(input logic [15:0] len, input int nbytes);
    in_item_t it;
    it.channel = 1'($urandom);
    it.frame_timestamp = $urandom;
    for (int i = 0; i < nbytes; i++) begin
      it.data_byte = 8'($urandom);
      it.first_of_nal = (i == 0);
      it.nal_length = (i > 0 && $urandom_range(0, 9) == 0) ? 16'($urandom) : len;
      if ($urandom_range(0, 7) == 0)
        it.frame_timestamp = $urandom;
      send_item(it);
    end
  endtask

  task automatic write_max_payload(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [15:0] mp_cfg, input int target);
    int eff;
    int len;
    int nbytes;
    int pick;
    int sent;
    eff = (mp_cfg < MIN_PAYLOAD) ? MIN_PAYLOAD : mp_cfg;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(0, 19);
      len = (eff <= 13) ? $urandom_range(1, 3 * eff + 2) : $urandom_range(1, 40);
      if (pick == 0) begin
        send_byte(8'($urandom), 1'b0, 16'($urandom), 1'($urandom), $urandom);
      end else if (pick == 1) begin
        // truncated unit, dropped by the next header
        nbytes = $urandom_range(1, len);
        send_nal(16'(len), nbytes);
        sent += nbytes;
      end else if (pick == 2) begin
        nbytes = $urandom_range(1, 4);
        send_nal(16'hFFFF, nbytes);
        sent += nbytes;
      end else begin
        send_nal(16'(len), len);
        sent += len;
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] mp_set [10];
    mp_set = '{16'd3, 16'd0, 16'd5, 16'hFFFF, 16'd2, 16'd7, 16'd9, 16'd1, 16'd1400, 16'd4};
    mp_set[6] = 16'($urandom_range(6, 13));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // byte with no active unit
    send_byte(8'hA5, 1'b0, 16'd10, 1'b0, 32'h0);
    // zero length acts as one
    send_byte(8'hFF, 1'b1, 16'd0, 1'b1, 32'hFFFF_FFFF);
    send_byte(8'h00, 1'b1, 16'd1, 1'b0, 32'h0);
    // length change inside a unit
    send_byte(8'h67, 1'b1, 16'd3, 1'b0, 32'h1234_5678);
    send_byte(8'h42, 1'b0, 16'd9, 1'b0, 32'h1234_5678);
    send_byte(8'h80, 1'b0, 16'd3, 1'b1, 32'h8765_4321);
    // longest unit, abandoned by a new header
    send_byte(8'h65, 1'b1, 16'hFFFF, 1'b1, 32'hDEAD_BEEF);
    send_byte(8'h11, 1'b0, 16'hFFFF, 1'b1, 32'hDEAD_BEEF);
    send_byte(8'h22, 1'b0, 16'hFFFF, 1'b1, 32'hDEAD_BEEF);
    drain_and_settle();

    write_max_payload(16'd3);
    send_byte(8'h7C, 1'b1, 16'd4, 1'b0, 32'h0000_0001);
    send_byte(8'hFF, 1'b0, 16'd4, 1'b0, 32'h0000_0001);
    send_byte(8'h00, 1'b0, 16'd4, 1'b0, 32'h0000_0001);
    send_byte(8'h5A, 1'b0, 16'd4, 1'b0, 32'h0000_0001);
    send_byte(8'h33, 1'b0, 16'd4, 1'b0, 32'h0000_0001);
    // register write in the middle of a fragmented unit
    send_byte(8'hE5, 1'b1, 16'd6, 1'b1, 32'h0000_0002);
    send_byte(8'h01, 1'b0, 16'd6, 1'b1, 32'h0000_0002);
    send_byte(8'h02, 1'b0, 16'd6, 1'b1, 32'h0000_0002);
    drain_and_settle();
    write_max_payload(16'd4);
    send_byte(8'h03, 1'b0, 16'd6, 1'b1, 32'h0000_0002);
    send_byte(8'h04, 1'b0, 16'd6, 1'b1, 32'h0000_0002);
    send_byte(8'h05, 1'b0, 16'd6, 1'b1, 32'h0000_0002);
    drain_and_settle();

    for (int p = 0; p < 10; p++) begin
      src_gaps = (p < 8) && ($urandom_range(0, 3) != 0);
      sink_gaps = (p < 8) && ($urandom_range(0, 3) != 0);
      write_max_payload(mp_set[p]);
      if (p == 2) begin
        hold_token++;
        send_nal(16'd30, 30);
      end
      run_phase(mp_set[p], 10);
      drain_and_settle();
    end

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
